@@ src/bca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block chain allocator package
// Shared field widths, table entry codes, command and status codes, and the
// result record passed from the sequencer to the output register.
// ----------------------------------------------------------------------------
package bca_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned LEN_W   = 22;
  localparam int unsigned BLK_W   = 12;
  localparam int unsigned ENTRY_W = 16;

  localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'h0000;
  localparam logic [ENTRY_W-1:0] ENTRY_END  = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_NEXT  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_BAD_BLOCK = 2'd3
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [BLK_W-1:0] blk;
    logic             chain_end;
  } res_t;

endpackage

@@ src/bca_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chain table memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bca_table #(
  parameter  int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [bca_pkg::ENTRY_W-1:0] wdata_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [bca_pkg::ENTRY_W-1:0] rdata_o
);

  logic [bca_pkg::ENTRY_W-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/bca_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block chain allocator sequencer
// Clears the table after reset, then runs allocate scans, free walks and
// next lookups against the table memory, one access per cycle.
// ----------------------------------------------------------------------------
module bca_seq #(
  parameter  int unsigned BLOCK_COUNT = 4096,
  parameter  int unsigned BLOCK_BYTES = 512,
  localparam int unsigned AW          = $clog2(BLOCK_COUNT)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [bca_pkg::CMD_W-1:0]   cmd_i,
  input  logic [bca_pkg::LEN_W-1:0]   len_i,
  input  logic [bca_pkg::BLK_W-1:0]   blk_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output bca_pkg::res_t               res_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [bca_pkg::ENTRY_W-1:0] mem_wdata_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [bca_pkg::ENTRY_W-1:0] mem_rdata_i
);

  localparam longint unsigned CapMax   = longint'(BLOCK_COUNT) * longint'(BLOCK_BYTES);
  localparam longint unsigned CapReset = longint'(BLOCK_COUNT - 2) * longint'(BLOCK_BYTES);
  localparam int unsigned     CAP_W    = $clog2(CapMax + 1);
  localparam int unsigned     CMP_W    = (CAP_W > bca_pkg::LEN_W) ? CAP_W : bca_pkg::LEN_W;

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_ALLOC     = 7'b0000100,
    S_ALLOC_END = 7'b0001000,
    S_FREE      = 7'b0010000,
    S_NEXT      = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_e;

  state_e                    state_q, state_d;
  logic [AW-1:0]             ptr_q, ptr_d;
  logic                      eval_vld_q, eval_vld_d;
  logic [AW-1:0]             eval_blk_q, eval_blk_d;
  logic [AW-1:0]             prev_q, prev_d;
  logic [AW-1:0]             first_q, first_d;
  logic                      any_q, any_d;
  logic [CAP_W-1:0]          acc_q, acc_d;
  logic [CAP_W-1:0]          cap_q, cap_d;
  logic [bca_pkg::LEN_W-1:0] len_q, len_d;
  logic                      first_step_q, first_step_d;
  logic                      fwd_q, fwd_d;
  bca_pkg::res_t             res_q, res_d;

  logic [CAP_W-1:0]            acc_n;
  logic [bca_pkg::ENTRY_W-1:0] ent;

  assign acc_n       = acc_q + CAP_W'(BLOCK_BYTES);
  assign ent         = fwd_q ? bca_pkg::ENTRY_FREE : mem_rdata_i;
  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    eval_vld_d   = eval_vld_q;
    eval_blk_d   = eval_blk_q;
    prev_d       = prev_q;
    first_d      = first_q;
    any_d        = any_q;
    acc_d        = acc_q;
    cap_d        = cap_q;
    len_d        = len_q;
    first_step_d = first_step_q;
    fwd_d        = fwd_q;
    res_d        = res_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = '0;
    mem_wdata_o  = bca_pkg::ENTRY_FREE;
    mem_raddr_o  = ptr_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ptr_q;
        mem_wdata_o = (ptr_q == '0) ? bca_pkg::ENTRY_END : bca_pkg::ENTRY_FREE;
        ptr_d       = ptr_q + 1'b1;
        if (ptr_q == AW'(BLOCK_COUNT - 1)) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        mem_raddr_o = AW'(blk_i);
        if (req_valid_i) begin
          res_d = '{status: bca_pkg::ST_BAD_BLOCK, blk: '0, chain_end: 1'b0};
          unique case (cmd_i) inside
            bca_pkg::CMD_ALLOC: begin
              if (64'(len_i) > CapMax) begin
                res_d.status = bca_pkg::ST_TOO_LARGE;
                state_d      = S_DONE;
              end else if (CMP_W'(len_i) >= CMP_W'(cap_q)) begin
                res_d.status = bca_pkg::ST_NO_SPACE;
                state_d      = S_DONE;
              end else begin
                ptr_d      = AW'(1);
                eval_vld_d = 1'b0;
                any_d      = 1'b0;
                acc_d      = '0;
                len_d      = len_i;
                state_d    = S_ALLOC;
              end
            end
            bca_pkg::CMD_FREE, bca_pkg::CMD_NEXT: begin
              if (blk_i == '0 || 32'(blk_i) >= BLOCK_COUNT) begin
                state_d = S_DONE;
              end else begin
                ptr_d        = AW'(blk_i);
                first_step_d = 1'b1;
                fwd_d        = 1'b0;
                state_d      = (cmd_i == bca_pkg::CMD_FREE) ? S_FREE : S_NEXT;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_ALLOC: begin
        // Issue the next read while the previous block's entry is judged.
        ptr_d      = ptr_q + 1'b1;
        eval_vld_d = 1'b1;
        eval_blk_d = ptr_q;
        if (eval_vld_q && mem_rdata_i == bca_pkg::ENTRY_FREE) begin
          if (any_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = prev_q;
            mem_wdata_o = bca_pkg::ENTRY_W'(eval_blk_q);
          end else begin
            first_d = eval_blk_q;
          end
          any_d  = 1'b1;
          prev_d = eval_blk_q;
          acc_d  = acc_n;
          cap_d  = cap_q - CAP_W'(BLOCK_BYTES);
          if (CMP_W'(acc_n) > CMP_W'(len_q)) begin
            state_d = S_ALLOC_END;
          end
        end
      end

      S_ALLOC_END: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = prev_q;
        mem_wdata_o = bca_pkg::ENTRY_END;
        res_d       = '{status: bca_pkg::ST_OK, blk: bca_pkg::BLK_W'(first_q),
                        chain_end: 1'b0};
        state_d     = S_DONE;
      end

      S_FREE: begin
        if (ent == bca_pkg::ENTRY_FREE) begin
          // Free start block is bad; a free link later on ends the walk.
          res_d.status = first_step_q ? bca_pkg::ST_BAD_BLOCK : bca_pkg::ST_OK;
          state_d      = S_DONE;
        end else begin
          mem_we_o     = 1'b1;
          mem_waddr_o  = ptr_q;
          mem_wdata_o  = bca_pkg::ENTRY_FREE;
          cap_d        = cap_q + CAP_W'(BLOCK_BYTES);
          first_step_d = 1'b0;
          if (ent == bca_pkg::ENTRY_END || 32'(ent) >= BLOCK_COUNT) begin
            res_d.status = bca_pkg::ST_OK;
            state_d      = S_DONE;
          end else begin
            // A link back to the entry being cleared reads as free.
            mem_raddr_o = AW'(ent);
            ptr_d       = AW'(ent);
            fwd_d       = (AW'(ent) == ptr_q);
          end
        end
      end

      S_NEXT: begin
        if (mem_rdata_i == bca_pkg::ENTRY_FREE) begin
          res_d.status = bca_pkg::ST_BAD_BLOCK;
        end else if (mem_rdata_i == bca_pkg::ENTRY_END) begin
          res_d.status    = bca_pkg::ST_OK;
          res_d.chain_end = 1'b1;
        end else begin
          res_d.status = bca_pkg::ST_OK;
          res_d.blk    = bca_pkg::BLK_W'(mem_rdata_i);
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      cap_q   <= CAP_W'(CapReset);
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cap_q   <= cap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    eval_vld_q   <= eval_vld_d;
    eval_blk_q   <= eval_blk_d;
    prev_q       <= prev_d;
    first_q      <= first_d;
    any_q        <= any_d;
    acc_q        <= acc_d;
    len_q        <= len_d;
    first_step_q <= first_step_d;
    fwd_q        <= fwd_d;
    res_q        <= res_d;
  end

endmodule

@@ src/block_chain_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block chain allocator
// File allocation table with one 16-bit entry per disk block: allocate a
// chain, free a chain, look up a block's successor.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the command, tdata the
//   byte length and block index. Each request yields exactly one response on
//   the m_axis channel (status, result block, chain end flag).
//   One request is in work at a time. Each command works as follows:
//     next lookup: read the given block's entry
//     allocate:    scan table entries from block 1 up to the highest block
//                  taken, linking each free one into the chain
//     free:        clear each chain entry in turn; a free start entry or a
//                  free link read along the walk ends it
//     rejected:    answer with no table access
//   The table has one read port and one write port, one read per cycle.
//   After reset the table is cleared entry by entry with s_axis_tready low.
//   Entry 0 is then reserved and all others free.
//   A response waits in the output register while m_axis_tready is low; the
//   next request is taken meanwhile, and its response holds until the
//   register drains.
// ----------------------------------------------------------------------------
module block_chain_allocator_unit #(
  parameter int unsigned BLOCK_COUNT = 4096,
  parameter int unsigned BLOCK_BYTES = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // byte_length[21:0], block_index[33:22], zero pad
  input  logic [1:0]  s_axis_tuser,  // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // status[1:0], result_block[13:2], chain_end[14], pad
);

  localparam int unsigned AW = $clog2(BLOCK_COUNT);

  logic                        res_valid;
  logic                        res_ready;
  bca_pkg::res_t               res;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [bca_pkg::ENTRY_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [bca_pkg::ENTRY_W-1:0] mem_rdata;

  logic          out_valid_q, out_valid_d;
  bca_pkg::res_t out_q;

  bca_seq #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .len_i       (s_axis_tdata[21:0]),
    .blk_i       (s_axis_tdata[33:22]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  bca_table #(
    .Depth (BLOCK_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: load when empty or draining this cycle.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.chain_end, out_q.blk, out_q.status};

endmodule

@@ src/bca_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block chain allocator port checker
// Watches the top-level ports for handshake and response-format slips.
// ----------------------------------------------------------------------------
module bca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // One request at a time: no acceptance in the cycle right after one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while previous one in work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled response dropped or changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] |->
      m_axis_tdata[13:2] == '0 && m_axis_tdata[1:0] == bca_pkg::ST_OK)
    else $error("chain end response with block or error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != bca_pkg::ST_OK |-> m_axis_tdata[15:2] == '0)
    else $error("error response carries block or chain end");

endmodule

bind block_chain_allocator_unit bca_checker u_bca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
